@@ design/note_step_sequencer_with_envelope_assert.svh @@
// Assertion helpers for the checker file of the sequencer.
`ifndef NOTE_STEP_SEQUENCER_WITH_ENVELOPE_ASSERT_SVH
`define NOTE_STEP_SEQUENCER_WITH_ENVELOPE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NSSE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NSSE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/nsse_pkg.sv @@
package nsse_pkg;

  // Field and register widths.
  localparam int LEN_W      = 10;
  localparam int IDX_W      = 10;
  localparam int VAL_W      = 24;
  localparam int CMD_W      = 3;
  localparam int DUR_W      = 16;
  localparam int RATE_W     = 16;
  localparam int ENV_W      = 64;
  localparam int MODE_W     = 2;
  localparam int LVL_W      = 16;
  localparam int TIME_W     = 16;
  localparam int SAMPLE_W   = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Datapath widths.
  localparam int COUNT_W   = 24;
  localparam int NOTE_W    = 32;
  localparam int TERM_W    = 32;
  localparam int SUM_W     = 34;
  localparam int OTHERS_W  = 26;
  localparam int MUL_A_W   = 24;
  localparam int DIVISOR_W = 26;
  localparam int QUO_W     = 24;
  localparam int PROD_W    = MUL_A_W + DIVISOR_W;
  localparam int DIV_BITS  = 4;
  localparam int NUM_TERMS = 4;
  localparam int TERM_IDX_W = 2;

  // Mode register bits.
  localparam int MODE_ELASTIC_BIT = 0;
  localparam int MODE_MANUAL_BIT  = 1;

  // Fixed values.
  localparam logic [DUR_W-1:0]  DUR_ZERO_UNITS = 16'd100;
  localparam logic [TERM_W-1:0] ONE_MS_Q8      = 32'd256;

  // Register reset values.
  localparam logic [LEN_W-1:0]  RST_PITCH_LEN = 10'd3;
  localparam logic [LEN_W-1:0]  RST_DUR_LEN   = 10'd3;
  localparam logic [RATE_W-1:0] RST_SPU       = 16'd11290;
  localparam logic [RATE_W-1:0] RST_MPU       = 16'd256;
  localparam logic [ENV_W-1:0]  RST_ENV       = 64'h0032_0064_0032_0014;
  localparam logic [MODE_W-1:0] RST_MODE      = 2'd0;
  localparam logic [LVL_W-1:0]  RST_SUS_LVL   = 16'd45875;

  typedef enum logic [CMD_W-1:0] {
    OP_TICK     = 3'd0,
    OP_WR_PITCH = 3'd1,
    OP_WR_DUR   = 3'd2,
    OP_BANG     = 3'd3,
    OP_RESTART  = 3'd4
  } nsse_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PITCH_LEN = 3'd0,
    REG_DUR_LEN   = 3'd1,
    REG_SPU       = 3'd2,
    REG_MPU       = 3'd3,
    REG_ENV       = 3'd4,
    REG_MODE      = 3'd5,
    REG_SUS_LVL   = 3'd6
  } nsse_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic wr_pitch;
    logic wr_dur;
    logic set_bang;
    logic clr_bang;
    logic restart;
    logic adv_pitch;
    logic adv_dur;
    logic dec_count;
    logic clr_note;
    logic load_note;
    logic load_count;
    logic load_note_len;
    logic load_elastic;
    logic load_sum;
    logic mul_term;
    logic div_start;
    logic store_term;
    logic emit;
  } nsse_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             manual;
    logic             bang;
    logic             count_zero;
    logic             rescale;
    logic             last_term;
    logic             div_done;
    logic             out_free;
  } nsse_status_t;

  // Duration entry as stored: zero becomes the default length, large values saturate.
  function automatic logic [DUR_W-1:0] clamp_dur(input logic [VAL_W-1:0] val);
    logic [DUR_W-1:0] res;
    if (val == '0) begin
      res = DUR_ZERO_UNITS;
    end else if (val[VAL_W-1:DUR_W] != '0) begin
      res = '1;
    end else begin
      res = val[DUR_W-1:0];
    end
    return res;
  endfunction

  // Integer milliseconds of a Q.8 time, saturated to the output width.
  function automatic logic [TIME_W-1:0] sat_time(input logic [TERM_W-1:0] t);
    logic [TIME_W-1:0] res;
    if (t[TERM_W-1:TIME_W+8] != '0) begin
      res = '1;
    end else begin
      res = t[TIME_W+7:8];
    end
    return res;
  endfunction

endpackage

@@ design/note_step_sequencer_with_envelope.sv @@
// Step sequencer driven by audio sample ticks, with per-note envelope times.
// The input channel (in_valid / in_stall) takes one command word at a time:
// a tick, a pitch or duration table write, a bang or a restart. Each tick
// returns exactly one word on the output channel (out_valid / out_stall)
// with the held pitch word, the note and sequence start flags, the attack,
// decay, sustain and release times in ms, and the sustain amplitude. The
// other commands return nothing. A tick that starts no note goes from
// dispatch to the emit step. A note start needs the table read and,
// outside manual mode, two products on the shared multiplier and the
// envelope sum. When the envelope must be rescaled to the note length,
// each of the four times takes one multiply and one pass through the
// divider (four quotient bits per cycle) before the word is written.
// The next word is accepted once the current one is finished.
// The output word sits in a register, so a new command is taken while the
// receiver stalls; a second tick waits for the register to drain.
// Reset (rst, synchronous) loads the register defaults, sets both table
// positions to their last entry and clears countdown, held word and bang.
// The tables are not cleared: an entry must be written before it is played.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
module note_step_sequencer_with_envelope #(
  parameter int TABLE_DEPTH = 1024,
  parameter int PITCH_WIDTH = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [nsse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nsse_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [nsse_pkg::CMD_W-1:0]        cmd,
  input  logic [nsse_pkg::IDX_W-1:0]        entry_index,
  input  logic [nsse_pkg::VAL_W-1:0]        entry_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [nsse_pkg::SAMPLE_W-1:0]     sample_value,
  output logic                              note_start,
  output logic                              sequence_start,
  output logic [nsse_pkg::TIME_W-1:0]       attack_time,
  output logic [nsse_pkg::TIME_W-1:0]       decay_time,
  output logic [nsse_pkg::TIME_W-1:0]       sustain_time,
  output logic [nsse_pkg::TIME_W-1:0]       release_time,
  output logic [nsse_pkg::LVL_W-1:0]        sustain_amplitude
);

  // Commands flow from the controller, status flows back from the datapath.
  nsse_pkg::nsse_cmd_t    ctl;
  nsse_pkg::nsse_status_t status;

  nsse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .ctl      (ctl)
  );

  // The datapath holds the tables, the configuration, the envelope
  // arithmetic and the output register.
  nsse_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PITCH_WIDTH (PITCH_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .entry_index       (entry_index),
    .entry_value       (entry_value),
    .ctl               (ctl),
    .status            (status),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .sample_value      (sample_value),
    .note_start        (note_start),
    .sequence_start    (sequence_start),
    .attack_time       (attack_time),
    .decay_time        (decay_time),
    .sustain_time      (sustain_time),
    .release_time      (release_time),
    .sustain_amplitude (sustain_amplitude)
  );

endmodule

@@ design/nsse_div.sv @@
module nsse_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [nsse_pkg::PROD_W-1:0]     dividend,
  input  logic [nsse_pkg::DIVISOR_W-1:0]  divisor,
  output logic                            done,
  output logic [nsse_pkg::QUO_W-1:0]      quotient
);

  localparam int DW    = nsse_pkg::DIVISOR_W;
  localparam int QW    = nsse_pkg::QUO_W;
  localparam int STEPS = QW / nsse_pkg::DIV_BITS;
  localparam int CW    = $clog2(STEPS);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] rem_next;
  logic [QW-1:0] lo;
  logic [QW-1:0] lo_next;
  logic [DW-1:0] dsr;

  // Restoring division, DIV_BITS quotient bits per step. The quotient bits
  // shift in at the bottom of the dividend register as its bits leave the top.
  always_comb begin : step_b
    logic [DW:0] trial;
    rem_next = rem;
    lo_next  = lo;
    for (int i = 0; i < nsse_pkg::DIV_BITS; i++) begin
      trial   = {rem_next, lo_next[QW-1]};
      lo_next = {lo_next[QW-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        rem_next   = DW'(trial - {1'b0, dsr});
        lo_next[0] = 1'b1;
      end else begin
        rem_next = trial[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[nsse_pkg::PROD_W-1 -: DW];
      lo  <= dividend[QW-1:0];
      dsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      lo  <= lo_next;
    end
  end

  assign quotient = lo;

endmodule

@@ design/nsse_datapath.sv @@
module nsse_datapath #(
  parameter int TABLE_DEPTH = 1024,
  parameter int PITCH_WIDTH = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [nsse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nsse_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [nsse_pkg::CMD_W-1:0]        cmd,
  input  logic [nsse_pkg::IDX_W-1:0]        entry_index,
  input  logic [nsse_pkg::VAL_W-1:0]        entry_value,
  input  nsse_pkg::nsse_cmd_t               ctl,
  output nsse_pkg::nsse_status_t            status,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [nsse_pkg::SAMPLE_W-1:0]     sample_value,
  output logic                              note_start,
  output logic                              sequence_start,
  output logic [nsse_pkg::TIME_W-1:0]       attack_time,
  output logic [nsse_pkg::TIME_W-1:0]       decay_time,
  output logic [nsse_pkg::TIME_W-1:0]       sustain_time,
  output logic [nsse_pkg::TIME_W-1:0]       release_time,
  output logic [nsse_pkg::LVL_W-1:0]        sustain_amplitude
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int LW = nsse_pkg::LEN_W;

  // Length limited to the table depth.
  function automatic logic [LW-1:0] eff_len(input logic [LW-1:0] len);
    logic [LW-1:0] res;
    if (int'(len) > TABLE_DEPTH) begin
      res = LW'(TABLE_DEPTH);
    end else begin
      res = len;
    end
    return res;
  endfunction

  function automatic logic [LW-1:0] last_pos(input logic [LW-1:0] len);
    logic [LW-1:0] e;
    e = eff_len(len);
    return (e == '0) ? '0 : e - 1'b1;
  endfunction

  // Returns {wrapped, next position}.
  function automatic logic [LW:0] advance(input logic [LW-1:0] pos, input logic [LW-1:0] len);
    logic [LW:0] n;
    logic [LW:0] res;
    n = {1'b0, pos} + 1'b1;
    if (n >= {1'b0, eff_len(len)}) begin
      res = {1'b1, {LW{1'b0}}};
    end else begin
      res = {1'b0, n[LW-1:0]};
    end
    return res;
  endfunction

  // Configuration registers.
  logic [LW-1:0]                   pitch_len;
  logic [LW-1:0]                   dur_len;
  logic [nsse_pkg::RATE_W-1:0]     spu;
  logic [nsse_pkg::RATE_W-1:0]     mpu;
  logic [nsse_pkg::ENV_W-1:0]      env;
  logic [nsse_pkg::MODE_W-1:0]     mode;
  logic [nsse_pkg::LVL_W-1:0]      sus_lvl;

  // Sequencer state.
  logic [LW-1:0]                   pitch_pos;
  logic [LW-1:0]                   dur_pos;
  logic [nsse_pkg::COUNT_W-1:0]    countdown;
  logic [nsse_pkg::SAMPLE_W-1:0]   held_value;
  logic                            bang_pending;

  // Captured input word.
  logic [nsse_pkg::CMD_W-1:0]      op_r;
  logic [nsse_pkg::IDX_W-1:0]      idx_r;
  logic [nsse_pkg::VAL_W-1:0]      val_r;

  // Tables and their registered read ports.
  logic [PITCH_WIDTH-1:0]          pitch_mem [TABLE_DEPTH];
  logic [nsse_pkg::DUR_W-1:0]      dur_mem [TABLE_DEPTH];
  logic [PITCH_WIDTH-1:0]          pitch_rd;
  logic [nsse_pkg::DUR_W-1:0]      dur_rd;

  // Envelope working registers.
  logic [nsse_pkg::TERM_W-1:0]     t [nsse_pkg::NUM_TERMS];
  logic [nsse_pkg::NOTE_W-1:0]     note_r;
  logic [nsse_pkg::SUM_W-1:0]      sum_r;
  logic [nsse_pkg::TERM_IDX_W-1:0] term_k;
  logic [nsse_pkg::PROD_W-1:0]     prod;
  logic [nsse_pkg::MUL_A_W-1:0]    mul_a;
  logic [nsse_pkg::DIVISOR_W-1:0]  mul_b;
  logic                            start_r;
  logic                            wrap_r;

  logic [LW:0]                     pitch_step;
  logic [LW:0]                     dur_step;
  logic                            idx_ok;
  logic                            div_done;
  logic [nsse_pkg::QUO_W-1:0]      quotient;
  logic [nsse_pkg::OTHERS_W-1:0]   others;
  logic [nsse_pkg::NOTE_W:0]       diff;

  assign pitch_step = advance(pitch_pos, pitch_len);
  assign dur_step   = advance(dur_pos, dur_len);
  assign idx_ok     = int'(idx_r) < TABLE_DEPTH;

  assign others = {2'b0, t[0][nsse_pkg::MUL_A_W-1:0]} + {2'b0, t[1][nsse_pkg::MUL_A_W-1:0]}
                + {2'b0, t[3][nsse_pkg::MUL_A_W-1:0]};
  assign diff   = {1'b0, note_r} - {7'b0, others};

  // The one multiplier is shared by the countdown, the note length and the rescale terms.
  always_comb begin
    if (ctl.mul_term) begin
      mul_a = t[term_k][nsse_pkg::MUL_A_W-1:0];
      mul_b = note_r[nsse_pkg::DIVISOR_W-1:0];
    end else if (ctl.load_count) begin
      mul_a = nsse_pkg::MUL_A_W'(dur_rd);
      mul_b = nsse_pkg::DIVISOR_W'(mpu);
    end else begin
      mul_a = nsse_pkg::MUL_A_W'(dur_rd);
      mul_b = nsse_pkg::DIVISOR_W'(spu);
    end
  end

  nsse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (prod),
    .divisor  (sum_r[nsse_pkg::DIVISOR_W-1:0]),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (ctl.wr_pitch && idx_ok) begin
      pitch_mem[AW'(idx_r)] <= PITCH_WIDTH'(val_r);
    end
    if (ctl.wr_dur && idx_ok) begin
      dur_mem[AW'(idx_r)] <= nsse_pkg::clamp_dur(val_r);
    end
    pitch_rd <= pitch_mem[AW'(pitch_pos)];
    dur_rd   <= dur_mem[AW'(dur_pos)];
  end

  // Configuration and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_len    <= nsse_pkg::RST_PITCH_LEN;
      dur_len      <= nsse_pkg::RST_DUR_LEN;
      spu          <= nsse_pkg::RST_SPU;
      mpu          <= nsse_pkg::RST_MPU;
      env          <= nsse_pkg::RST_ENV;
      mode         <= nsse_pkg::RST_MODE;
      sus_lvl      <= nsse_pkg::RST_SUS_LVL;
      pitch_pos    <= last_pos(nsse_pkg::RST_PITCH_LEN);
      dur_pos      <= last_pos(nsse_pkg::RST_DUR_LEN);
      countdown    <= '0;
      held_value   <= '0;
      bang_pending <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          nsse_pkg::REG_PITCH_LEN: begin
            pitch_len <= cfg_data[LW-1:0];
            pitch_pos <= last_pos(cfg_data[LW-1:0]);
          end
          nsse_pkg::REG_DUR_LEN: begin
            dur_len <= cfg_data[LW-1:0];
            dur_pos <= last_pos(cfg_data[LW-1:0]);
          end
          nsse_pkg::REG_SPU:     spu     <= cfg_data[nsse_pkg::RATE_W-1:0];
          nsse_pkg::REG_MPU:     mpu     <= cfg_data[nsse_pkg::RATE_W-1:0];
          nsse_pkg::REG_ENV:     env     <= cfg_data;
          nsse_pkg::REG_MODE:    mode    <= cfg_data[nsse_pkg::MODE_W-1:0];
          nsse_pkg::REG_SUS_LVL: sus_lvl <= cfg_data[nsse_pkg::LVL_W-1:0];
          default: ;
        endcase
      end
      if (ctl.set_bang) begin
        bang_pending <= 1'b1;
      end
      if (ctl.clr_bang) begin
        bang_pending <= 1'b0;
      end
      if (ctl.restart) begin
        pitch_pos    <= last_pos(pitch_len);
        dur_pos      <= last_pos(dur_len);
        countdown    <= '0;
        bang_pending <= 1'b0;
      end
      if (ctl.adv_pitch) begin
        pitch_pos <= pitch_step[LW-1:0];
      end
      if (ctl.adv_dur) begin
        dur_pos <= dur_step[LW-1:0];
      end
      if (ctl.dec_count) begin
        countdown <= countdown - 1'b1;
      end
      if (ctl.load_count) begin
        countdown <= prod[nsse_pkg::COUNT_W+7:8];
      end
      if (ctl.load_note) begin
        held_value <= nsse_pkg::SAMPLE_W'(pitch_rd);
      end
      if (ctl.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and the output word.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op_r  <= cmd;
      idx_r <= entry_index;
      val_r <= entry_value;
    end
    if (ctl.clr_note) begin
      start_r <= 1'b0;
      wrap_r  <= 1'b0;
    end
    if (ctl.adv_pitch) begin
      wrap_r <= pitch_step[LW];
    end
    if (ctl.load_note || ctl.load_count || ctl.mul_term) begin
      prod <= nsse_pkg::PROD_W'(mul_a) * nsse_pkg::PROD_W'(mul_b);
    end
    if (ctl.load_note) begin
      start_r <= 1'b1;
      term_k  <= '0;
      for (int k = 0; k < nsse_pkg::NUM_TERMS; k++) begin
        t[k] <= {8'b0, (env[16*k +: 16] == '0) ? 16'd1 : env[16*k +: 16], 8'b0};
      end
    end
    if (ctl.load_note_len) begin
      note_r <= prod[nsse_pkg::NOTE_W-1:0];
    end
    // Elastic sustain fills what the other three phases leave, at least one millisecond.
    if (ctl.load_elastic && mode[nsse_pkg::MODE_ELASTIC_BIT]) begin
      if (note_r > nsse_pkg::NOTE_W'(others) && diff >= 33'(nsse_pkg::ONE_MS_Q8)) begin
        t[2] <= diff[nsse_pkg::NOTE_W-1:0];
      end else begin
        t[2] <= nsse_pkg::ONE_MS_Q8;
      end
    end
    if (ctl.load_sum) begin
      sum_r <= nsse_pkg::SUM_W'(t[0]) + nsse_pkg::SUM_W'(t[1])
             + nsse_pkg::SUM_W'(t[2]) + nsse_pkg::SUM_W'(t[3]);
    end
    if (ctl.store_term) begin
      t[term_k] <= nsse_pkg::TERM_W'(quotient);
      term_k    <= term_k + 1'b1;
    end
    if (ctl.emit) begin
      sample_value      <= held_value;
      note_start        <= start_r;
      sequence_start    <= start_r && wrap_r;
      attack_time       <= start_r ? nsse_pkg::sat_time(t[0]) : '0;
      decay_time        <= start_r ? nsse_pkg::sat_time(t[1]) : '0;
      sustain_time      <= start_r ? nsse_pkg::sat_time(t[2]) : '0;
      release_time      <= start_r ? nsse_pkg::sat_time(t[3]) : '0;
      sustain_amplitude <= sus_lvl;
    end
  end

  assign status.op         = op_r;
  assign status.manual     = mode[nsse_pkg::MODE_MANUAL_BIT];
  assign status.bang       = bang_pending;
  assign status.count_zero = (countdown == '0);
  assign status.rescale    = (sum_r > nsse_pkg::SUM_W'(note_r));
  assign status.last_term  = (term_k == '1);
  assign status.div_done   = div_done;
  assign status.out_free   = !out_valid || !out_stall;

endmodule

@@ design/nsse_ctrl.sv @@
module nsse_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  nsse_pkg::nsse_status_t status,
  output nsse_pkg::nsse_cmd_t    ctl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_LOAD,
    S_COUNT,
    S_NOTE_LEN,
    S_ELASTIC,
    S_SUM,
    S_CHECK,
    S_MUL,
    S_DIV_START,
    S_DIV_RUN,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    ctl         = '0;
    ctl.capture = in_valid && (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_IDLE;
        unique case (status.op)
          nsse_pkg::OP_WR_PITCH: ctl.wr_pitch = 1'b1;
          nsse_pkg::OP_WR_DUR:   ctl.wr_dur   = 1'b1;
          nsse_pkg::OP_BANG:     ctl.set_bang = 1'b1;
          nsse_pkg::OP_RESTART:  ctl.restart  = 1'b1;
          nsse_pkg::OP_TICK: begin
            ctl.clr_note = 1'b1;
            priority if (status.manual && status.bang) begin
              ctl.adv_pitch = 1'b1;
              ctl.clr_bang  = 1'b1;
              state_next    = S_READ;
            end else if (status.manual) begin
              state_next = S_EMIT;
            end else if (status.count_zero) begin
              ctl.adv_pitch = 1'b1;
              ctl.adv_dur   = 1'b1;
              state_next    = S_READ;
            end else begin
              ctl.dec_count = 1'b1;
              state_next    = S_EMIT;
            end
          end
          default: ;
        endcase
      end
      S_READ: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        ctl.load_note = 1'b1;
        state_next    = status.manual ? S_EMIT : S_COUNT;
      end
      S_COUNT: begin
        ctl.load_count = 1'b1;
        state_next     = S_NOTE_LEN;
      end
      S_NOTE_LEN: begin
        ctl.load_note_len = 1'b1;
        state_next        = S_ELASTIC;
      end
      S_ELASTIC: begin
        ctl.load_elastic = 1'b1;
        state_next       = S_SUM;
      end
      S_SUM: begin
        ctl.load_sum = 1'b1;
        state_next   = S_CHECK;
      end
      S_CHECK: begin
        state_next = status.rescale ? S_MUL : S_EMIT;
      end
      S_MUL: begin
        ctl.mul_term = 1'b1;
        state_next   = S_DIV_START;
      end
      S_DIV_START: begin
        ctl.div_start = 1'b1;
        state_next    = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        if (status.div_done) begin
          ctl.store_term = 1'b1;
          state_next     = status.last_term ? S_EMIT : S_MUL;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ design/nsse_check.sv @@
`include "note_step_sequencer_with_envelope_assert.svh"

module nsse_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [nsse_pkg::SAMPLE_W-1:0] sample_value,
  input logic                          note_start
);

  // An accepted word stalls the input in the cycle after it is taken.
  `NSSE_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall, "accept did not stall input")

  // A new output word only appears while a command is being worked on.
  `NSSE_ASSERT_NOW(a_word_from_work, $rose(out_valid), $past(in_stall), "output word without work")

  // Leaving reset, both channels are quiet.
  `NSSE_ASSERT_NOW(a_reset_quiet, $past(rst), !out_valid && !in_stall, "busy after reset")

  // A stalled output word holds.
  `NSSE_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(sample_value) && $stable(note_start), "stalled word changed")

endmodule

bind note_step_sequencer_with_envelope nsse_check u_nsse_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .sample_value (sample_value),
  .note_start   (note_start)
);
